### design/sdf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdf_pkg
// Shared types and constants of the sensor data framer.
// ----------------------------------------------------------------------------
package sdf_pkg;

	localparam int unsigned FRAME_LEN   = 43;
	localparam int unsigned NUM_CH      = 8;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [7:0] HDR0      = 8'hAA;
	localparam logic [7:0] HDR1      = 8'h55;
	localparam logic [7:0] LEN_BYTE  = 8'd41;
	localparam logic [7:0] TYPE_DATA = 8'h01;

	localparam int unsigned IDX_W = $clog2(FRAME_LEN);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

	// One frame worth of payload, checksum already computed.
	typedef struct packed {
		logic [7:0]                chk;
		logic [NUM_CH-1:0][31:0]   pres;
		logic [15:0]               angle;
		logic [31:0]               seq;
	} frame_t;

endpackage : sdf_pkg
`default_nettype wire

### design/sensor_data_framer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sensor_data_framer
// Packs one sample set into a 43-byte frame and sends it one byte a transaction.
// The first byte of a frame passes through the queue, the frame record and the output register.
// The serializer sends one output byte per cycle while a frame is queued and out_ready holds.
// The front queue holds QUEUE_DEPTH frames, so input is taken while a frame sends.
// Reset: asynchronous, clears sequence number, queue and output valid.
// ----------------------------------------------------------------------------
module sensor_data_framer #(
	parameter int unsigned QUEUE_DEPTH = sdf_pkg::QUEUE_DEPTH
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [15:0]         angle,
	input  wire logic signed [31:0]  s1_ch0,
	input  wire logic signed [31:0]  s1_ch1,
	input  wire logic signed [31:0]  s1_ch2,
	input  wire logic signed [31:0]  s1_ch3,
	input  wire logic signed [31:0]  s2_ch0,
	input  wire logic signed [31:0]  s2_ch1,
	input  wire logic signed [31:0]  s2_ch2,
	input  wire logic signed [31:0]  s2_ch3,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [7:0]               out_byte,
	output logic                     last
);
	import sdf_pkg::*;

	logic   push;
	frame_t push_data;
	logic   q_full;
	logic   pop;
	logic   q_not_empty;
	frame_t q_head;

	sdf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.angle     (angle),
		.s1_ch0    (s1_ch0),
		.s1_ch1    (s1_ch1),
		.s1_ch2    (s1_ch2),
		.s1_ch3    (s1_ch3),
		.s2_ch0    (s2_ch0),
		.s2_ch1    (s2_ch1),
		.s2_ch2    (s2_ch2),
		.s2_ch3    (s2_ch3),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	sdf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	sdf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.last        (last)
	);

endmodule : sensor_data_framer
`default_nettype wire

### design/sdf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdf_front
// Accepts sample sets, stamps the sequence number and computes the checksum.
// ----------------------------------------------------------------------------
module sdf_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [15:0]         angle,
	input  wire logic signed [31:0]  s1_ch0,
	input  wire logic signed [31:0]  s1_ch1,
	input  wire logic signed [31:0]  s1_ch2,
	input  wire logic signed [31:0]  s1_ch3,
	input  wire logic signed [31:0]  s2_ch0,
	input  wire logic signed [31:0]  s2_ch1,
	input  wire logic signed [31:0]  s2_ch2,
	input  wire logic signed [31:0]  s2_ch3,
	input  wire logic                q_full,
	output logic                     push,
	output sdf_pkg::frame_t          push_data
);
	import sdf_pkg::*;

	logic [31:0] seq_q;
	logic [31:0] word_x;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	assign word_x = seq_q
		^ 32'(s1_ch0) ^ 32'(s1_ch1) ^ 32'(s1_ch2) ^ 32'(s1_ch3)
		^ 32'(s2_ch0) ^ 32'(s2_ch1) ^ 32'(s2_ch2) ^ 32'(s2_ch3);

	always_comb begin
		push_data.seq   = seq_q;
		push_data.angle = angle;
		push_data.pres  = {32'(s2_ch3), 32'(s2_ch2), 32'(s2_ch1), 32'(s2_ch0),
		                   32'(s1_ch3), 32'(s1_ch2), 32'(s1_ch1), 32'(s1_ch0)};
		push_data.chk   = word_x[7:0] ^ word_x[15:8] ^ word_x[23:16] ^ word_x[31:24]
			^ angle[7:0] ^ angle[15:8] ^ LEN_BYTE ^ TYPE_DATA;
	end

	// Advance the sequence number once per accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= '0;
		end else if (push) begin
			seq_q <= seq_q + 32'd1;
		end
	end

endmodule : sdf_front
`default_nettype wire

### design/sdf_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdf_queue
// Short frame queue between the front and the serializer (depth >= 2).
// ----------------------------------------------------------------------------
module sdf_queue #(
	parameter int unsigned DEPTH = sdf_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire sdf_pkg::frame_t  push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic                  not_empty,
	output sdf_pkg::frame_t       head
);
	import sdf_pkg::*;

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	frame_t           mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_FULL);
	assign not_empty = (count_q != '0);
	assign head      = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule : sdf_queue
`default_nettype wire

### design/sdf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdf_back
// Serializes one frame record into 43 bytes behind an output register.
// ----------------------------------------------------------------------------
module sdf_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_not_empty,
	input  wire sdf_pkg::frame_t  q_head,
	output logic                  pop,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [7:0]            out_byte,
	output logic                  last
);
	import sdf_pkg::*;

	frame_t                     rec_q;
	logic                       active_q;
	logic [IDX_W-1:0]           idx_q;
	logic                       out_valid_q;
	logic [7:0]                 out_byte_q;
	logic                       last_q;
	logic                       adv;
	logic                       at_end;
	logic [FRAME_LEN*8-1:0]     frame_bits;
	logic [7:0]                 cur_byte;

	// Little-endian fields fall into byte order by plain concatenation.
	assign frame_bits = {rec_q.chk, rec_q.pres, rec_q.angle, rec_q.seq,
	                     TYPE_DATA, LEN_BYTE, HDR1, HDR0};
	assign cur_byte   = frame_bits[{idx_q, 3'b000} +: 8];

	assign adv    = !out_valid_q || out_ready;
	assign at_end = (idx_q == LAST_IDX);
	assign pop    = q_not_empty && (!active_q || (adv && at_end));

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			rec_q <= q_head;
		end
		if (adv && active_q) begin
			out_byte_q <= cur_byte;
			last_q     <= at_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= active_q;
			end
			if (pop) begin
				active_q <= 1'b1;
				idx_q    <= '0;
			end else if (adv && active_q) begin
				if (at_end) begin
					active_q <= 1'b0;
				end else begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
		end
	end

endmodule : sdf_back
`default_nettype wire

### tb/sensor_data_framer_tb.sv
// ----------------------------------------------------------------------------
// sensor_data_framer_tb
// Sends sample sets to the framer and checks every frame byte against a
// frame builder kept in the bench. Directed sets cover field extremes,
// negative pressures and back-to-back sets; random sets follow, with random
// gaps on the input side and stalls on the output side, and a closing stretch
// with neither.
// ----------------------------------------------------------------------------
module sensor_data_framer_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import sdf_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES   = 10;

	typedef struct packed {
		logic [15:0]             angle;
		logic [NUM_CH-1:0][31:0] pres;
	} sample_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} frame_byte_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [15:0]        angle = '0;
	logic signed [31:0] s1_ch0 = '0;
	logic signed [31:0] s1_ch1 = '0;
	logic signed [31:0] s1_ch2 = '0;
	logic signed [31:0] s1_ch3 = '0;
	logic signed [31:0] s2_ch0 = '0;
	logic signed [31:0] s2_ch1 = '0;
	logic signed [31:0] s2_ch2 = '0;
	logic signed [31:0] s2_ch3 = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [7:0]         out_byte;
	logic               last;

	frame_byte_t pending_bytes[$];
	logic [31:0] next_seq = '0;
	int unsigned mismatch_cnt = 0;
	bit          in_gaps = 1'b1;
	bit          out_stalls = 1'b1;

	sensor_data_framer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.angle     (angle),
		.s1_ch0    (s1_ch0),
		.s1_ch1    (s1_ch1),
		.s1_ch2    (s1_ch2),
		.s1_ch3    (s1_ch3),
		.s2_ch0    (s2_ch0),
		.s2_ch1    (s2_ch1),
		.s2_ch2    (s2_ch2),
		.s2_ch3    (s2_ch3),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.last      (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Build the frame for one sample set and queue its bytes in transmit order.
	function automatic void predict_frame(input sample_t s);
		logic [7:0]  fb [FRAME_LEN];
		logic [7:0]  chk;
		frame_byte_t entry;
		fb[0] = HDR0;
		fb[1] = HDR1;
		fb[2] = LEN_BYTE;
		fb[3] = TYPE_DATA;
		for (int i = 0; i < 4; i++)
			fb[4 + i] = next_seq[8*i +: 8];
		fb[8] = s.angle[7:0];
		fb[9] = s.angle[15:8];
		for (int k = 0; k < NUM_CH; k++)
			for (int i = 0; i < 4; i++)
				fb[10 + 4*k + i] = s.pres[k][8*i +: 8];
		chk = '0;
		for (int i = 2; i < FRAME_LEN - 1; i++)
			chk ^= fb[i];
		fb[FRAME_LEN - 1] = chk;
		for (int i = 0; i < FRAME_LEN; i++) begin
			entry.data = fb[i];
			entry.last = (i == FRAME_LEN - 1);
			pending_bytes.push_back(entry);
		end
		next_seq = next_seq + 32'd1;
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return '1;
			3: return '0;
			4: return 32'h0 - 32'($urandom_range(1, 1000));
			default: return $urandom();
		endcase
	endfunction

	function automatic sample_t rand_sample();
		sample_t s;
		s.angle = 16'($urandom_range(0, 65535));
		for (int k = 0; k < NUM_CH; k++)
			s.pres[k] = rand_word();
		return s;
	endfunction

	// Present one sample set and hold it until the transaction completes.
	task automatic send_set(input sample_t s);
		in_valid <= 1'b1;
		angle    <= s.angle;
		s1_ch0   <= s.pres[0];
		s1_ch1   <= s.pres[1];
		s1_ch2   <= s.pres[2];
		s1_ch3   <= s.pres[3];
		s2_ch0   <= s.pres[4];
		s2_ch1   <= s.pres[5];
		s2_ch2   <= s.pres[6];
		s2_ch3   <= s.pres[7];
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_frame(s);
		if (in_gaps && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	task automatic test_zero_sets();
		sample_t s;
		s = '0;
		repeat (2) send_set(s);
	endtask

	task automatic test_field_extremes();
		sample_t s;
		s.angle = 16'hFFFF;
		for (int k = 0; k < NUM_CH; k++) s.pres[k] = 32'h7FFF_FFFF;
		send_set(s);
		s.angle = 16'h0000;
		for (int k = 0; k < NUM_CH; k++) s.pres[k] = 32'h8000_0000;
		send_set(s);
		s.angle = 16'hFFFF;
		for (int k = 0; k < NUM_CH; k++) s.pres[k] = '1;
		send_set(s);
		s.angle = 16'hA5A5;
		for (int k = 0; k < NUM_CH; k++) s.pres[k] = 32'hAAAA_AAAA;
		send_set(s);
		s.angle = 16'h5A5A;
		for (int k = 0; k < NUM_CH; k++) s.pres[k] = 32'h5555_5555;
		send_set(s);
		// distinct bytes per channel expose any swap in byte or channel order
		s.angle = 16'h1234;
		for (int k = 0; k < NUM_CH; k++) s.pres[k] = 32'h4433_2211 ^ {4{8'(k << 4)}};
		send_set(s);
	endtask

	task automatic test_negative_pressures();
		sample_t s;
		s.angle = 16'h0100;
		for (int k = 0; k < NUM_CH; k++)
			s.pres[k] = (k % 2 == 0) ? 32'h0 - 32'(k + 1) : 32'(k * 1000);
		send_set(s);
		s.angle = 16'h00FF;
		for (int k = 0; k < NUM_CH; k++) s.pres[k] = 32'h0 - 32'(100000 * (k + 1));
		send_set(s);
	endtask

	task automatic test_back_to_back();
		in_gaps    = 1'b0;
		out_stalls = 1'b0;
		repeat (6) send_set(rand_sample());
		in_gaps    = 1'b1;
		out_stalls = 1'b1;
	endtask

	task automatic test_random_sets(input int unsigned count);
		for (int unsigned i = 0; i < count; i++) begin
			// every 25 sets, pick at random whether each side idles
			if (i % 25 == 0) begin
				in_gaps    = ($urandom_range(0, 2) != 0);
				out_stalls = ($urandom_range(0, 2) != 0);
			end
			send_set(rand_sample());
		end
	endtask

	task automatic test_quiet_tail(input int unsigned count);
		in_gaps    = 1'b0;
		out_stalls = 1'b0;
		repeat (count) send_set(rand_sample());
	endtask

	// Output side: random stall bursts while enabled.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_stalls && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		frame_byte_t exp_b;
		if (arst_n && out_valid && out_ready) begin
			if (pending_bytes.size() == 0) begin
				$error("unexpected byte: out_byte %h last %b", out_byte, last);
				mismatch_cnt++;
			end else begin
				exp_b = pending_bytes.pop_front();
				if (out_byte !== exp_b.data) begin
					$error("out_byte: expected %h, got %h", exp_b.data, out_byte);
					mismatch_cnt++;
				end
				if (last !== exp_b.last) begin
					$error("last: expected %b, got %b", exp_b.last, last);
					mismatch_cnt++;
				end
			end
		end
	end

	// Watchdog: abort when no transaction moves on either side for too long.
	initial begin
		int unsigned idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_zero_sets();
		test_field_extremes();
		test_negative_pressures();
		test_back_to_back();
		test_random_sets(190);
		test_quiet_tail(25);

		in_valid <= 1'b0;
		while (pending_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule : sensor_data_framer_tb
